// ===== sv/spf_pkg.sv =====
// Shared types and constants for the smallest-prime-factor factorization block.
package spf_pkg;

   localparam int VALUE_W     = 16;
   localparam int FACTOR_W    = 11;
   localparam int MAX_RESULTS = 10;
   localparam int CNT_W       = $clog2(MAX_RESULTS);

   typedef enum logic [1:0] {
      KIND_FACTOR,
      KIND_EMPTY,
      KIND_RANGE
   } kind_type;

   typedef struct packed {
      kind_type            kind;
      logic [VALUE_W-1:0]  value;
   } cmd_type;

   typedef struct packed {
      logic [FACTOR_W-1:0] factor;
      logic                last;
      logic                empty_res;
      logic                out_of_range;
   } rsp_type;

   typedef enum logic [2:0] {
      SV_CLEAR,
      SV_PROBE,
      SV_PCHECK,
      SV_MARK_RD,
      SV_MARK_CHK,
      SV_DONE
   } sieve_state_type;

   typedef enum logic {
      BK_IDLE,
      BK_WALK
   } back_state_type;

endpackage

// ===== sv/prime_factorization_spf.sv =====
// Top level of the smallest-prime-factor factorization block.
//
// After reset the block builds a table holding, for every index 0..TABLE_LIMIT, its
// smallest prime factor and the matching cofactor, so factoring needs no divider.
// The build is a clearing pass over the whole table, then the sieve, which probes each
// index and marks the multiples of every prime whose square fits in the table.
// req_full stays high until the table is complete. Each query then
// returns its prime factors in ascending order, one result transaction per factor,
// with rsp_last on the final one; 0 and 1 give one transaction with rsp_empty_res,
// values above TABLE_LIMIT one with rsp_out_of_range. The back end spends one state per
// query on the first table read (the single registered read port of the table memory
// requires it), then queues one result per cycle while the result queue has room; a
// flagged query needs no table read. A two-entry command queue separates
// the classifying front end from the back end, and a four-entry result queue lets
// queries keep flowing while results wait for rsp_pop.
module prime_factorization_spf #(
   parameter int TABLE_LIMIT = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   input  logic [spf_pkg::VALUE_W-1:0]   req_value,
   output logic                          req_full,
   input  logic                          rsp_pop,
   output logic                          rsp_empty,
   output logic [spf_pkg::FACTOR_W-1:0]  rsp_factor,
   output logic                          rsp_last,
   output logic                          rsp_empty_res,
   output logic                          rsp_out_of_range
);

   localparam int IW = $clog2(TABLE_LIMIT + 1);

   logic             table_ready;
   logic             cmd_pop, cmd_empty;
   spf_pkg::cmd_type cmd;
   spf_pkg::rsp_type rsp;

   // table lookup port between back end and table
   logic          lk_en;
   logic [IW-1:0] lk_addr, lk_spf, lk_cof;

   spf_front #(
      .TABLE_LIMIT (TABLE_LIMIT)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .ready     (table_ready),
      .req_push  (req_push),
      .req_value (req_value),
      .req_full  (req_full),
      .cmd_pop   (cmd_pop),
      .cmd_empty (cmd_empty),
      .cmd       (cmd)
   );

   spf_table #(
      .TABLE_LIMIT (TABLE_LIMIT)
   ) u_table (
      .clock   (clock),
      .reset   (reset),
      .lk_en   (lk_en),
      .lk_addr (lk_addr),
      .lk_spf  (lk_spf),
      .lk_cof  (lk_cof),
      .ready   (table_ready)
   );

   spf_back #(
      .TABLE_LIMIT (TABLE_LIMIT)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .lk_en     (lk_en),
      .lk_addr   (lk_addr),
      .lk_spf    (lk_spf),
      .lk_cof    (lk_cof),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp       (rsp)
   );

   assign rsp_factor       = rsp.factor;
   assign rsp_last         = rsp.last;
   assign rsp_empty_res    = rsp.empty_res;
   assign rsp_out_of_range = rsp.out_of_range;

   // no query is taken while the table is still being built
   a_full_until_ready : assert property (@(posedge clock)
      !table_ready |-> req_full)
      else $error("query accepted before table complete");

   // nothing can come out before the table exists
   a_no_rsp_before_ready : assert property (@(posedge clock) disable iff (reset)
      !table_ready |-> rsp_empty)
      else $error("result present before table complete");

   // flagged results are single, final and carry no factor
   a_flag_result : assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && (rsp_empty_res || rsp_out_of_range))
         |-> (rsp_last && (rsp_factor == '0) && !(rsp_empty_res && rsp_out_of_range)))
      else $error("malformed flagged result");

   // once built, the table stays ready until reset
   a_ready_sticky : assert property (@(posedge clock) disable iff (reset)
      table_ready |=> table_ready)
      else $error("table ready dropped");

endmodule

// ===== sv/spf_fifo.sv =====
// Small register FIFO used for the command queue and the result queue.
module spf_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   localparam int AW = $clog2(DEPTH);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [AW-1:0]    wptr_ff, wptr_in;
   logic [AW-1:0]    rptr_ff, rptr_in;
   logic [AW:0]      count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == (AW+1)'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = store_ff[rptr_ff];

   always_comb begin
      wptr_in  = do_push ? wptr_ff + 1'b1 : wptr_ff;
      rptr_in  = do_pop  ? rptr_ff + 1'b1 : rptr_ff;
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wptr_ff] <= wdata;
      end
   end

endmodule

// ===== sv/spf_front.sv =====
// Front end: accepts queries, classifies them and queues commands for the back end.
module spf_front #(
   parameter int TABLE_LIMIT = 1024
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         ready,
   input  logic                         req_push,
   input  logic [spf_pkg::VALUE_W-1:0]  req_value,
   output logic                         req_full,
   input  logic                         cmd_pop,
   output logic                         cmd_empty,
   output spf_pkg::cmd_type             cmd
);

   localparam int CW = spf_pkg::VALUE_W + 1;

   spf_pkg::cmd_type cmd_new;
   logic             q_full;
   logic             q_push;

   assign req_full = !ready || q_full;
   assign q_push   = req_push && !req_full;

   always_comb begin
      cmd_new.value = req_value;
      if ({1'b0, req_value} > CW'(TABLE_LIMIT)) begin
         cmd_new.kind = spf_pkg::KIND_RANGE;
      end else if (req_value < spf_pkg::VALUE_W'(2)) begin
         cmd_new.kind = spf_pkg::KIND_EMPTY;
      end else begin
         cmd_new.kind = spf_pkg::KIND_FACTOR;
      end
   end

   spf_fifo #(
      .WIDTH ($bits(spf_pkg::cmd_type)),
      .DEPTH (2)
   ) u_cmd_q (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wdata (cmd_new),
      .full  (q_full),
      .pop   (cmd_pop),
      .rdata (cmd),
      .empty (cmd_empty)
   );

endmodule

// ===== sv/spf_table.sv =====
// Factor table: sieve sequencer filling {smallest prime factor, cofactor} per index.
module spf_table #(
   parameter int TABLE_LIMIT = 1024
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 lk_en,
   input  logic [$clog2(TABLE_LIMIT+1)-1:0]     lk_addr,
   output logic [$clog2(TABLE_LIMIT+1)-1:0]     lk_spf,
   output logic [$clog2(TABLE_LIMIT+1)-1:0]     lk_cof,
   output logic                                 ready
);

   localparam int IW    = $clog2(TABLE_LIMIT + 1);
   localparam int SW    = 2 * IW + 1;
   localparam int DEPTH = TABLE_LIMIT + 1;

   logic [2*IW-1:0] mem [DEPTH];
   logic [2*IW-1:0] rd_ff;

   spf_pkg::sieve_state_type state_ff, state_in;
   logic [IW-1:0] p_ff, p_in;
   logic [IW-1:0] i_ff, i_in;
   logic [IW-1:0] k_ff, k_in;
   logic [SW-1:0] sq_ff, sq_in;

   logic            wr_en, rd_en;
   logic [IW-1:0]   wr_addr, rd_addr;
   logic [2*IW-1:0] wr_data;

   logic [IW:0]   i_sum;
   logic          mark_end, p_last, sq_fits, unmarked;
   logic [IW-1:0] rd_spf;

   assign rd_spf   = rd_ff[2*IW-1:IW];
   assign lk_spf   = rd_spf;
   assign lk_cof   = rd_ff[IW-1:0];
   assign unmarked = (rd_spf == '0);
   assign i_sum    = {1'b0, i_ff} + {1'b0, p_ff};
   assign mark_end = i_sum > (IW+1)'(TABLE_LIMIT);
   assign p_last   = (p_ff == IW'(TABLE_LIMIT));
   assign sq_fits  = sq_ff <= SW'(TABLE_LIMIT);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         spf_pkg::SV_CLEAR: begin
            if (i_ff == IW'(TABLE_LIMIT)) state_in = spf_pkg::SV_PROBE;
         end
         spf_pkg::SV_PROBE: state_in = spf_pkg::SV_PCHECK;
         spf_pkg::SV_PCHECK: begin
            if (unmarked && sq_fits)   state_in = spf_pkg::SV_MARK_RD;
            else if (p_last)           state_in = spf_pkg::SV_DONE;
            else                       state_in = spf_pkg::SV_PROBE;
         end
         spf_pkg::SV_MARK_RD: state_in = spf_pkg::SV_MARK_CHK;
         spf_pkg::SV_MARK_CHK: begin
            if (!mark_end)             state_in = spf_pkg::SV_MARK_RD;
            else if (p_last)           state_in = spf_pkg::SV_DONE;
            else                       state_in = spf_pkg::SV_PROBE;
         end
         spf_pkg::SV_DONE: state_in = spf_pkg::SV_DONE;
         default: state_in = spf_pkg::SV_CLEAR;
      endcase
   end

   // outputs and sieve counters
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = i_ff;
      wr_data = '0;
      rd_en   = 1'b0;
      rd_addr = p_ff;
      ready   = 1'b0;
      p_in    = p_ff;
      i_in    = i_ff;
      k_in    = k_ff;
      sq_in   = sq_ff;
      unique case (state_ff)
         spf_pkg::SV_CLEAR: begin
            wr_en = 1'b1;
            i_in  = i_ff + 1'b1;
            p_in  = IW'(2);
            sq_in = SW'(4);
         end
         spf_pkg::SV_PROBE: begin
            rd_en = 1'b1;
         end
         spf_pkg::SV_PCHECK: begin
            // prime: own factor, cofactor one
            if (unmarked) begin
               wr_en   = 1'b1;
               wr_addr = p_ff;
               wr_data = {p_ff, IW'(1)};
            end
            if (unmarked && sq_fits) begin
               i_in = IW'(sq_ff);
               k_in = p_ff;
            end else begin
               p_in  = p_ff + 1'b1;
               sq_in = sq_ff + SW'({p_ff, 1'b1});
            end
         end
         spf_pkg::SV_MARK_RD: begin
            rd_en   = 1'b1;
            rd_addr = i_ff;
         end
         spf_pkg::SV_MARK_CHK: begin
            // i = k * p; first prime to reach it is the smallest
            if (unmarked) begin
               wr_en   = 1'b1;
               wr_data = {p_ff, k_ff};
            end
            i_in = IW'(i_sum);
            k_in = k_ff + 1'b1;
            if (mark_end) begin
               p_in  = p_ff + 1'b1;
               sq_in = sq_ff + SW'({p_ff, 1'b1});
            end
         end
         spf_pkg::SV_DONE: begin
            ready   = 1'b1;
            rd_en   = lk_en;
            rd_addr = lk_addr;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= spf_pkg::SV_CLEAR;
         i_ff     <= '0;
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
      end
   end

   always_ff @(posedge clock) begin
      p_ff  <= p_in;
      k_ff  <= k_in;
      sq_ff <= sq_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

endmodule

// ===== sv/spf_back.sv =====
// Back end: walks the factor chain through the table and queues result transactions.
module spf_back #(
   parameter int TABLE_LIMIT = 1024
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 cmd_empty,
   input  spf_pkg::cmd_type                     cmd,
   output logic                                 cmd_pop,
   output logic                                 lk_en,
   output logic [$clog2(TABLE_LIMIT+1)-1:0]     lk_addr,
   input  logic [$clog2(TABLE_LIMIT+1)-1:0]     lk_spf,
   input  logic [$clog2(TABLE_LIMIT+1)-1:0]     lk_cof,
   input  logic                                 rsp_pop,
   output logic                                 rsp_empty,
   output spf_pkg::rsp_type                     rsp
);

   localparam int IW = $clog2(TABLE_LIMIT + 1);

   spf_pkg::back_state_type state_ff, state_in;
   logic [spf_pkg::CNT_W-1:0] cnt_ff, cnt_in;

   spf_pkg::rsp_type res_data;
   logic             res_push, res_full;
   logic             is_factor, last;

   assign is_factor = (cmd.kind == spf_pkg::KIND_FACTOR);
   assign last      = (lk_cof <= IW'(1))
                   || (cnt_ff == spf_pkg::CNT_W'(spf_pkg::MAX_RESULTS - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         spf_pkg::BK_IDLE: begin
            if (!cmd_empty && is_factor) state_in = spf_pkg::BK_WALK;
         end
         spf_pkg::BK_WALK: begin
            if (!res_full && last) state_in = spf_pkg::BK_IDLE;
         end
         default: state_in = spf_pkg::BK_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd_pop  = 1'b0;
      lk_en    = 1'b0;
      lk_addr  = IW'(cmd.value);
      res_push = 1'b0;
      res_data = '0;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         spf_pkg::BK_IDLE: begin
            if (!cmd_empty) begin
               if (is_factor) begin
                  cmd_pop = 1'b1;
                  lk_en   = 1'b1;
                  cnt_in  = '0;
               end else if (!res_full) begin
                  cmd_pop               = 1'b1;
                  res_push              = 1'b1;
                  res_data.last         = 1'b1;
                  res_data.empty_res    = (cmd.kind == spf_pkg::KIND_EMPTY);
                  res_data.out_of_range = (cmd.kind == spf_pkg::KIND_RANGE);
               end
            end
         end
         spf_pkg::BK_WALK: begin
            // table read data holds while the result queue is full
            if (!res_full) begin
               res_push        = 1'b1;
               res_data.factor = spf_pkg::FACTOR_W'(lk_spf);
               res_data.last   = last;
               if (!last) begin
                  lk_en   = 1'b1;
                  lk_addr = lk_cof;
                  cnt_in  = cnt_ff + 1'b1;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= spf_pkg::BK_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   spf_fifo #(
      .WIDTH ($bits(spf_pkg::rsp_type)),
      .DEPTH (4)
   ) u_rsp_q (
      .clock (clock),
      .reset (reset),
      .push  (res_push),
      .wdata (res_data),
      .full  (res_full),
      .pop   (rsp_pop),
      .rdata (rsp),
      .empty (rsp_empty)
   );

endmodule
